[src/sldec_pkg.sv]
// Package with the phase type, event codes and register indexes of the frame decoder.
`timescale 1ns / 1ps

package sldec_pkg;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_DEV   = 4'd2,
    PH_MSG   = 4'd3,
    PH_LENL  = 4'd4,
    PH_LENH  = 4'd5,
    PH_DATA  = 4'd6,
    PH_CRCL  = 4'd7,
    PH_CRCH  = 4'd8
  } phase_t;

  localparam int EventWidth = 3;
  typedef logic [EventWidth-1:0] event_t;

  localparam event_t EV_NONE    = 3'd0;
  localparam event_t EV_PAYLOAD = 3'd1;
  localparam event_t EV_GOOD    = 3'd2;
  localparam event_t EV_BADCRC  = 3'd3;
  localparam event_t EV_BADLEN  = 3'd4;
  localparam event_t EV_SYNC    = 3'd5;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_SYNC_FIRST  = 2'd0;
  localparam cfg_index_t CFG_SYNC_SECOND = 2'd1;
  localparam cfg_index_t CFG_CRC_POLY    = 2'd2;
  localparam cfg_index_t CFG_MAX_PAYLOAD = 2'd3;

  localparam logic [7:0]  SYNC_FIRST_RESET  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND_RESET = 8'hAA;
  localparam logic [15:0] CRC_POLY_RESET    = 16'h1021;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd255;

endpackage

[src/sldec_crc_byte.sv]
// One-byte MSB-first CRC-16 update with a programmable generator polynomial.
`timescale 1ns / 1ps

module sldec_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  input  logic [15:0] poly,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

[src/sync_length_crc16_frame_decoder.sv]
// Top level of the sync, header, length and CRC-16 frame decoder.
//
//   channel | handshake          | words
//   --------+--------------------+--------------------------------------------
//   rx      | rx_valid, rx_stall | rx_byte
//   res     | res_valid,res_stall| event_res, payload_byte, payload_index,
//           |                    | device_id, message_id, payload_length,
//           |                    | last_of_frame
//   cfg     | cfg_write          | cfg_index, cfg_data
//
// Each accepted byte produces exactly one result word, registered in the cycle after it is accepted.
// The phase step and the CRC byte update sit between the input and the result register.
// One byte per cycle is sustained while the result side takes its words.
// rx_stall is high only while a result word waits and res_stall is high.
// Reset is synchronous; it restores the config and state registers and res_valid, and starts hunting for sync.
`timescale 1ns / 1ps

module sync_length_crc16_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [7:0]  device_id,
  output logic [7:0]  message_id,
  output logic [15:0] payload_length,
  output logic        last_of_frame,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [15:0] crc_polynomial;
  logic [15:0] max_payload;

  sldec_pkg::phase_t phase, phase_next;
  logic [7:0]  frame_device, frame_device_next;
  logic [7:0]  frame_message, frame_message_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic               accept;
  logic [15:0]        crc_base;
  logic [15:0]        crc_fed;
  logic [15:0]        len_full;
  logic [15:0]        seen_inc;
  sldec_pkg::event_t  ev;
  logic [7:0]         pbyte;
  logic [15:0]        pidx;

  assign rx_stall = res_valid & res_stall;
  assign accept   = rx_valid & ~rx_stall;
  assign len_full = {rx_byte, frame_length[7:0]};
  assign seen_inc = bytes_seen + 16'd1;
  assign crc_base = (phase == sldec_pkg::PH_DEV) ? 16'h0000 : running_crc;

  sldec_crc_byte u_crc (
    .crc_in  (crc_base),
    .data_in (rx_byte),
    .poly    (crc_polynomial),
    .crc_out (crc_fed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first     <= sldec_pkg::SYNC_FIRST_RESET;
      sync_second    <= sldec_pkg::SYNC_SECOND_RESET;
      crc_polynomial <= sldec_pkg::CRC_POLY_RESET;
      max_payload    <= sldec_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sldec_pkg::CFG_SYNC_FIRST:  sync_first     <= cfg_data[7:0];
        sldec_pkg::CFG_SYNC_SECOND: sync_second    <= cfg_data[7:0];
        sldec_pkg::CFG_CRC_POLY:    crc_polynomial <= cfg_data;
        sldec_pkg::CFG_MAX_PAYLOAD: max_payload    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      sldec_pkg::PH_HUNT: begin
        phase_next = (rx_byte == sync_first) ? sldec_pkg::PH_SYNC2 : sldec_pkg::PH_HUNT;
      end
      sldec_pkg::PH_SYNC2: begin
        phase_next = (rx_byte == sync_second) ? sldec_pkg::PH_DEV : sldec_pkg::PH_HUNT;
      end
      sldec_pkg::PH_DEV:  phase_next = sldec_pkg::PH_MSG;
      sldec_pkg::PH_MSG:  phase_next = sldec_pkg::PH_LENL;
      sldec_pkg::PH_LENL: phase_next = sldec_pkg::PH_LENH;
      sldec_pkg::PH_LENH: begin
        if (len_full > max_payload) begin
          phase_next = sldec_pkg::PH_HUNT;
        end else if (len_full == 16'd0) begin
          phase_next = sldec_pkg::PH_CRCL;
        end else begin
          phase_next = sldec_pkg::PH_DATA;
        end
      end
      sldec_pkg::PH_DATA: begin
        phase_next = (seen_inc >= frame_length) ? sldec_pkg::PH_CRCL : sldec_pkg::PH_DATA;
      end
      sldec_pkg::PH_CRCL: phase_next = sldec_pkg::PH_CRCH;
      sldec_pkg::PH_CRCH: phase_next = sldec_pkg::PH_HUNT;
      default:            phase_next = sldec_pkg::PH_HUNT;
    endcase
  end

  always_comb begin
    ev                 = sldec_pkg::EV_NONE;
    pbyte              = 8'h00;
    pidx               = 16'h0000;
    frame_device_next  = frame_device;
    frame_message_next = frame_message;
    frame_length_next  = frame_length;
    bytes_seen_next    = bytes_seen;
    running_crc_next   = running_crc;
    crc_low_byte_next  = crc_low_byte;
    case (phase)
      sldec_pkg::PH_SYNC2: begin
        if (rx_byte != sync_second) begin
          ev = sldec_pkg::EV_SYNC;
        end
      end
      sldec_pkg::PH_DEV: begin
        frame_device_next = rx_byte;
        running_crc_next  = crc_fed;
      end
      sldec_pkg::PH_MSG: begin
        frame_message_next = rx_byte;
        running_crc_next   = crc_fed;
      end
      sldec_pkg::PH_LENL: begin
        frame_length_next = {8'h00, rx_byte};
        running_crc_next  = crc_fed;
      end
      sldec_pkg::PH_LENH: begin
        frame_length_next = len_full;
        running_crc_next  = crc_fed;
        bytes_seen_next   = 16'h0000;
        if (len_full > max_payload) begin
          ev = sldec_pkg::EV_BADLEN;
        end
      end
      sldec_pkg::PH_DATA: begin
        running_crc_next = crc_fed;
        ev               = sldec_pkg::EV_PAYLOAD;
        pbyte            = rx_byte;
        pidx             = bytes_seen;
        bytes_seen_next  = seen_inc;
      end
      sldec_pkg::PH_CRCL: begin
        crc_low_byte_next = rx_byte;
      end
      sldec_pkg::PH_CRCH: begin
        ev = ({rx_byte, crc_low_byte} == running_crc) ? sldec_pkg::EV_GOOD
                                                      : sldec_pkg::EV_BADCRC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sldec_pkg::PH_HUNT;
      frame_device  <= 8'h00;
      frame_message <= 8'h00;
      frame_length  <= 16'h0000;
      bytes_seen    <= 16'h0000;
      running_crc   <= 16'h0000;
      crc_low_byte  <= 8'h00;
    end else if (accept) begin
      phase         <= phase_next;
      frame_device  <= frame_device_next;
      frame_message <= frame_message_next;
      frame_length  <= frame_length_next;
      bytes_seen    <= bytes_seen_next;
      running_crc   <= running_crc_next;
      crc_low_byte  <= crc_low_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_res      <= ev;
      payload_byte   <= pbyte;
      payload_index  <= pidx;
      device_id      <= frame_device_next;
      message_id     <= frame_message_next;
      payload_length <= frame_length_next;
      last_of_frame  <= (ev == sldec_pkg::EV_GOOD) || (ev == sldec_pkg::EV_BADCRC) ||
                        (ev == sldec_pkg::EV_BADLEN);
    end
  end

`ifndef ASSERT_OFF
  // Every accepted byte leaves a result word in the output register.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted byte produced no result word");

  // Payload fields are zero on every word that is not a payload byte.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_res != sldec_pkg::EV_PAYLOAD) |->
      (payload_byte == 8'h00 && payload_index == 16'h0000))
    else $error("payload fields not zero outside a payload word");

  // The payload phase is entered only with a nonzero length and ends on its last byte.
  a_data_bounds: assert property (@(posedge clk) disable iff (rst)
    (phase == sldec_pkg::PH_DATA) |-> (frame_length != 16'd0 && bytes_seen < frame_length))
    else $error("payload counter outside the declared length");

  // A verdict word always closes a frame and is never a payload word.
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && last_of_frame) |->
      (event_res == sldec_pkg::EV_GOOD || event_res == sldec_pkg::EV_BADCRC ||
       event_res == sldec_pkg::EV_BADLEN))
    else $error("end of frame flagged without a verdict");
`endif

endmodule

[tb/sync_length_crc16_frame_decoder_tb.sv]
// Testbench that streams good and broken frames through the decoder and checks every word.
`timescale 1ns / 1ps

import sldec_pkg::*;

typedef struct packed {
  logic [2:0]  ev;
  logic [7:0]  pbyte;
  logic [15:0] pidx;
  logic [7:0]  dev;
  logic [7:0]  msg;
  logic [15:0] len;
  logic        last;
} decoder_word_t;

function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b,
                                             logic [15:0] poly);
  logic [15:0] c;
  c = crc ^ {b, 8'h00};
  for (int i = 0; i < 8; i++) begin
    if (c[15]) c = {c[14:0], 1'b0} ^ poly;
    else c = {c[14:0], 1'b0};
  end
  return c;
endfunction

class frame_scoreboard;
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;
  logic [15:0] poly;
  logic [15:0] max_len;
  phase_t      phase;
  logic [7:0]  dev;
  logic [7:0]  msg;
  logic [15:0] len;
  logic [15:0] seen;
  logic [15:0] crc;
  logic [7:0]  crc_lo;
  decoder_word_t pending_words[$];
  int errors;
  int verdicts[6];

  function new();
    sync_a  = SYNC_FIRST_RESET;
    sync_b  = SYNC_SECOND_RESET;
    poly    = CRC_POLY_RESET;
    max_len = MAX_PAYLOAD_RESET;
    phase   = PH_HUNT;
    dev     = '0;
    msg     = '0;
    len     = '0;
    seen    = '0;
    crc     = '0;
    crc_lo  = '0;
    errors  = 0;
    foreach (verdicts[i]) verdicts[i] = 0;
  endfunction

  function void set_reg(cfg_index_t idx, logic [15:0] v);
    case (idx)
      CFG_SYNC_FIRST:  sync_a = v[7:0];
      CFG_SYNC_SECOND: sync_b = v[7:0];
      CFG_CRC_POLY:    poly = v;
      CFG_MAX_PAYLOAD: max_len = v;
      default: ;
    endcase
  endfunction

  function void take_byte(logic [7:0] b);
    decoder_word_t w;
    w = '0;
    w.ev = EV_NONE;
    case (phase)
      PH_SYNC2: begin
        if (b == sync_b) begin
          phase = PH_DEV;
        end else begin
          w.ev = EV_SYNC;
          phase = PH_HUNT;
        end
      end
      PH_DEV: begin
        dev = b;
        crc = crc16_update(16'h0000, b, poly);
        phase = PH_MSG;
      end
      PH_MSG: begin
        msg = b;
        crc = crc16_update(crc, b, poly);
        phase = PH_LENL;
      end
      PH_LENL: begin
        len = {8'h00, b};
        crc = crc16_update(crc, b, poly);
        phase = PH_LENH;
      end
      PH_LENH: begin
        len = {b, len[7:0]};
        crc = crc16_update(crc, b, poly);
        seen = '0;
        if (len > max_len) begin
          w.ev = EV_BADLEN;
          phase = PH_HUNT;
        end else if (len == 16'd0) begin
          phase = PH_CRCL;
        end else begin
          phase = PH_DATA;
        end
      end
      PH_DATA: begin
        crc = crc16_update(crc, b, poly);
        w.ev = EV_PAYLOAD;
        w.pbyte = b;
        w.pidx = seen;
        seen = seen + 16'd1;
        if (seen >= len) phase = PH_CRCL;
      end
      PH_CRCL: begin
        crc_lo = b;
        phase = PH_CRCH;
      end
      PH_CRCH: begin
        w.ev = ({b, crc_lo} == crc) ? EV_GOOD : EV_BADCRC;
        phase = PH_HUNT;
      end
      default: begin
        phase = (b == sync_a) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
    w.dev = dev;
    w.msg = msg;
    w.len = len;
    w.last = (w.ev == EV_GOOD) || (w.ev == EV_BADCRC) || (w.ev == EV_BADLEN);
    pending_words.push_back(w);
  endfunction

  task report_mismatch(string what);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", what);
  endtask

  task check_word(decoder_word_t got);
    decoder_word_t want;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("word %h with nothing expected", got));
      return;
    end
    want = pending_words.pop_front();
    if (got.ev <= EV_SYNC) verdicts[got.ev]++;
    if (got !== want)
      report_mismatch($sformatf({"ev %0d/%0d byte %h/%h idx %0d/%0d dev %h/%h msg %h/%h ",
                                 "len %0d/%0d last %b/%b (got/exp)"},
                                got.ev, want.ev, got.pbyte, want.pbyte, got.pidx, want.pidx,
                                got.dev, want.dev, got.msg, want.msg, got.len, want.len,
                                got.last, want.last));
  endtask
endclass

module sync_length_crc16_frame_decoder_tb;

  typedef enum int {FR_GOOD, FR_BADCRC, FR_BADLEN, FR_BADSYNC, FR_NOISE} frame_kind_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_FROM  = 1100;

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_stall;
  logic [7:0]  rx_byte;
  logic        res_valid;
  logic        res_stall;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  device_id;
  logic [7:0]  message_id;
  logic [15:0] payload_length;
  logic        last_of_frame;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  frame_scoreboard board = new();
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;
  int bytes_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;

  sync_length_crc16_frame_decoder dut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .event_res(event_res),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .device_id(device_id),
    .message_id(message_id),
    .payload_length(payload_length),
    .last_of_frame(last_of_frame),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count,
                 board.pending_words.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    decoder_word_t w;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        w.ev = event_res;
        w.pbyte = payload_byte;
        w.pidx = payload_index;
        w.dev = device_id;
        w.msg = message_id;
        w.len = payload_length;
        w.last = last_of_frame;
        board.check_word(w);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold) begin
        stall_left = 400;
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      res_stall <= (stall_left > 0);
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (rx_stall);
    board.take_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    rx_valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(logic [7:0] sa, logic [7:0] sb, logic [15:0] poly,
                              logic [15:0] maxl);
    logic [15:0] vals[4];
    vals[CFG_SYNC_FIRST]  = {8'($urandom), sa};
    vals[CFG_SYNC_SECOND] = {8'($urandom), sb};
    vals[CFG_CRC_POLY]    = poly;
    vals[CFG_MAX_PAYLOAD] = maxl;
    for (int i = CFG_SYNC_FIRST; i <= CFG_MAX_PAYLOAD; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      board.set_reg(cfg_index_t'(i), vals[i]);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic send_frame(frame_kind_t kind, logic [7:0] d, logic [7:0] m, int plen);
    logic [7:0] body[$];
    logic [15:0] c;
    if (kind == FR_NOISE) begin
      repeat (plen) send_byte(8'($urandom));
      return;
    end
    send_byte(board.sync_a);
    if (kind == FR_BADSYNC) begin
      send_byte(board.sync_b ^ 8'($urandom_range(1, 255)));
      return;
    end
    body.push_back(d);
    body.push_back(m);
    body.push_back(plen[7:0]);
    body.push_back(plen[15:8]);
    if (kind != FR_BADLEN) repeat (plen) body.push_back(8'($urandom));
    send_byte(board.sync_b);
    c = '0;
    foreach (body[i]) begin
      c = crc16_update(c, body[i], board.poly);
      send_byte(body[i]);
    end
    if (kind == FR_BADLEN) return;
    if (kind == FR_BADCRC) c ^= 16'($urandom_range(1, 65535));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  function automatic int pick_length(int maxl);
    if ($urandom_range(0, 24) == 0) return (maxl < 260) ? maxl : 260;
    return $urandom_range(0, (maxl < 12) ? maxl : 12);
  endfunction

  function automatic int pick_oversize(int maxl);
    if ($urandom_range(0, 3) == 0) return 65535;
    return $urandom_range(maxl + 1, (maxl + 600 < 65535) ? maxl + 600 : 65535);
  endfunction

  task automatic run_frames(int target);
    frame_kind_t kind;
    int r;
    int plen;
    int maxl;
    while (bytes_sent < target) begin
      if (bytes_sent >= QUIET_FROM) idle_on = 1'b0;
      maxl = board.max_len;
      r = $urandom_range(0, 99);
      if (r < 55) kind = FR_GOOD;
      else if (r < 72) kind = FR_BADCRC;
      else if (r < 80) kind = FR_BADLEN;
      else if (r < 90) kind = FR_BADSYNC;
      else kind = FR_NOISE;
      if (kind == FR_BADLEN && maxl == 65535) kind = FR_GOOD;
      if (kind == FR_NOISE) plen = $urandom_range(1, 6);
      else if (kind == FR_BADLEN) plen = pick_oversize(maxl);
      else plen = pick_length(maxl);
      send_frame(kind, 8'($urandom), 8'($urandom), plen);
    end
  endtask

  initial begin
    rst = 1'b1;
    rx_valid = 1'b0;
    rx_byte = '0;
    res_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Repeated first sync byte, then a zero-length frame, an oversize length and a bad CRC.
    send_byte(SYNC_FIRST_RESET);
    send_byte(SYNC_FIRST_RESET);
    send_frame(FR_GOOD, 8'h00, 8'hFF, 0);
    send_frame(FR_BADLEN, 8'h01, 8'h02, 256);
    send_frame(FR_BADCRC, 8'hFF, 8'h00, 1);
    wait_drained();

    load_setting(SYNC_FIRST_RESET, SYNC_SECOND_RESET, CRC_POLY_RESET, MAX_PAYLOAD_RESET);
    run_frames(230);
    wait_drained();

    load_setting(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
    run_frames(280);
    long_hold = 1'b1;
    run_frames(430);
    wait_drained();

    load_setting(8'hFF, 8'h00, 16'h0000, 16'h0000);
    run_frames(630);
    wait_drained();

    load_setting(8'h7E, 8'h7E, 16'h8005, 16'd16);
    run_frames(830);
    wait_drained();

    load_setting(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom_range(1, 40)));
    run_frames(1030);
    wait_drained();

    load_setting(SYNC_FIRST_RESET, SYNC_SECOND_RESET, CRC_POLY_RESET, MAX_PAYLOAD_RESET);
    run_frames(1250);
    wait_drained();

    if (board.pending_words.size() != 0)
      board.report_mismatch($sformatf("%0d words never arrived", board.pending_words.size()));
    $display("Run fed %0d bytes under %0d register settings, with a long receiver hold.",
             bytes_sent, settings_used);
    $display("Words seen: %0d payload, %0d good, %0d bad CRC, %0d oversize, %0d sync lost.",
             board.verdicts[EV_PAYLOAD], board.verdicts[EV_GOOD], board.verdicts[EV_BADCRC],
             board.verdicts[EV_BADLEN], board.verdicts[EV_SYNC]);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/sldec_pkg.sv
src/sldec_crc_byte.sv
src/sync_length_crc16_frame_decoder.sv
tb/sync_length_crc16_frame_decoder_tb.sv
